// ===== hw/rtl/plbs_pkg.sv =====
package plbs_pkg;

  // LED indexes, in service priority order
  localparam int unsigned LedCount = 4;
  localparam logic [1:0] LED_GREEN1 = 2'd0;
  localparam logic [1:0] LED_GREEN2 = 2'd1;
  localparam logic [1:0] LED_RED1   = 2'd2;
  localparam logic [1:0] LED_RED2   = 2'd3;

  // Opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Widths
  localparam int unsigned DurWidth = 15;
  localparam int unsigned CntWidth = 16;

  // Register map (word index = paddr[2])
  localparam int unsigned AddrWidth = 3;
  localparam logic REG_GREEN_DURATION = 1'b0;
  localparam logic REG_RED_DURATION   = 1'b1;

  localparam logic [DurWidth-1:0] DurReset = 15'd50;

  typedef struct packed {
    logic [DurWidth-1:0] green_duration;
    logic [DurWidth-1:0] red_duration;
  } cfg_t;

  typedef logic [LedCount-1:0] led_vec_t;

endpackage

// ===== hw/rtl/plbs_cfg_regs.sv =====
module plbs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plbs_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output plbs_pkg::cfg_t                    cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes on the APB access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_duration <= plbs_pkg::DurReset;
      cfg.red_duration   <= plbs_pkg::DurReset;
    end else if (wr_en) begin
      case (reg_sel)
        plbs_pkg::REG_GREEN_DURATION: cfg.green_duration <= pwdata[plbs_pkg::DurWidth-1:0];
        plbs_pkg::REG_RED_DURATION:   cfg.red_duration   <= pwdata[plbs_pkg::DurWidth-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      plbs_pkg::REG_GREEN_DURATION: prdata = {17'd0, cfg.green_duration};
      plbs_pkg::REG_RED_DURATION:   prdata = {17'd0, cfg.red_duration};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/plbs_led_engine.sv =====
module plbs_led_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic                     opcode,
  input  logic [1:0]               led_select,
  input  plbs_pkg::cfg_t           cfg,
  output logic                     busy,
  output plbs_pkg::led_vec_t       level_next
);

  plbs_pkg::led_vec_t                pending;
  plbs_pkg::led_vec_t                pending_next;
  plbs_pkg::led_vec_t                level;
  logic [plbs_pkg::CntWidth-1:0]     count [plbs_pkg::LedCount];
  logic [plbs_pkg::CntWidth-1:0]     count_next [plbs_pkg::LedCount];

  logic                              any_pending;
  logic [1:0]                        serve_idx;
  logic                              is_green;
  logic [plbs_pkg::DurWidth-1:0]     dur;
  logic [plbs_pkg::CntWidth-1:0]     cnt_inc;
  logic                              first_half;
  logic                              done;

  // Fixed-priority pick of the LED to serve on a tick
  always_comb begin
    any_pending = |pending;
    if (pending[plbs_pkg::LED_GREEN1])      serve_idx = plbs_pkg::LED_GREEN1;
    else if (pending[plbs_pkg::LED_GREEN2]) serve_idx = plbs_pkg::LED_GREEN2;
    else if (pending[plbs_pkg::LED_RED1])   serve_idx = plbs_pkg::LED_RED1;
    else                                    serve_idx = plbs_pkg::LED_RED2;
  end

  // Counter advance and half compares for the served LED
  assign is_green   = ~serve_idx[1];
  assign dur        = is_green ? cfg.green_duration : cfg.red_duration;
  assign cnt_inc    = count[serve_idx] + 16'd1;
  assign first_half = cnt_inc < {1'b0, dur};
  assign done       = cnt_inc >= {dur, 1'b0};
  assign busy       = (opcode == plbs_pkg::OP_REQUEST) & pending[led_select];

  // Next state
  always_comb begin
    pending_next = pending;
    level_next   = level;
    for (int i = 0; i < plbs_pkg::LedCount; i++) count_next[i] = count[i];
    if (opcode == plbs_pkg::OP_REQUEST) begin
      pending_next[led_select] = 1'b1;
    end else if (any_pending) begin
      level_next[serve_idx] = is_green ? ~first_half : first_half;
      if (done) begin
        count_next[serve_idx]   = '0;
        pending_next[serve_idx] = 1'b0;
      end else begin
        count_next[serve_idx] = cnt_inc;
      end
    end
  end

  // State update once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      level   <= '0;
      for (int i = 0; i < plbs_pkg::LedCount; i++) count[i] <= '0;
    end else if (fire) begin
      pending <= pending_next;
      level   <= level_next;
      for (int i = 0; i < plbs_pkg::LedCount; i++) count[i] <= count_next[i];
    end
  end

endmodule

// ===== hw/rtl/priority_led_blink_sequencer_core.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------------
// input    | in_valid / in_ready        | opcode, led_select
// output   | out_valid / out_ready      | busy_res, green_one, green_two, red_one,
//          |                            | red_two
// config   | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// One transaction per cycle while out_ready is high, via the input register,
// then the result register. LED state is updated as an item leaves the input
// register. Synchronous active-high reset clears all LED state and sets both
// durations to 50. A stalled output holds its result while the input register
// still takes one more item; both stages then hold until out_ready returns.
module priority_led_blink_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [1:0]                      led_select,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            busy_res,
  output logic                            green_one,
  output logic                            green_two,
  output logic                            red_one,
  output logic                            red_two,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plbs_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  plbs_pkg::cfg_t      cfg;
  plbs_pkg::led_vec_t  level_next;
  logic                busy;

  logic                s1_valid;
  logic                s1_opcode;
  logic [1:0]          s1_select;
  logic                out_free;
  logic                s1_fire;

  plbs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage handshakes
  assign out_free = ~out_valid | out_ready;
  assign s1_fire  = s1_valid & out_free;
  assign in_ready = ~s1_valid | out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode <= opcode;
      s1_select <= led_select;
    end
  end

  plbs_led_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .opcode     (s1_opcode),
    .led_select (s1_select),
    .cfg        (cfg),
    .busy       (busy),
    .level_next (level_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      busy_res  <= busy;
      green_one <= level_next[plbs_pkg::LED_GREEN1];
      green_two <= level_next[plbs_pkg::LED_GREEN2];
      red_one   <= level_next[plbs_pkg::LED_RED1];
      red_two   <= level_next[plbs_pkg::LED_RED2];
    end
  end

endmodule
